// ----- sv/fdg_pkg.sv -----
// Shared constants, types and curve table generation for the fade envelope gain block.
package fdg_pkg;

  localparam int MAX_REGION_SAMPLES = 1048576;
  localparam int SAMPLE_BITS        = 24;
  localparam int CURVE_TABLE_DEPTH  = 1024;

  localparam int LEN_BITS = $clog2(MAX_REGION_SAMPLES + 1);
  localparam int POS_BITS = $clog2(MAX_REGION_SAMPLES);

  // Fade positions and gains are Q0.16 with one extra bit so that unity fits.
  localparam int FRAC_BITS = 16;
  localparam int GAIN_BITS = FRAC_BITS + 1;
  localparam int GAIN_ONE  = 1 << FRAC_BITS;

  localparam int CURVE_ADDR_BITS = $clog2(CURVE_TABLE_DEPTH);
  localparam int CURVE_IDX_BITS  = CURVE_ADDR_BITS + 1;
  localparam int FRAC_SHIFT      = FRAC_BITS - CURVE_ADDR_BITS;

  localparam int MCAND_BITS    = (SAMPLE_BITS > GAIN_BITS) ? SAMPLE_BITS : GAIN_BITS + 1;
  localparam int PROD_BITS     = MCAND_BITS + 1 + GAIN_BITS - FRAC_BITS;
  localparam int STEP_CNT_BITS = $clog2(GAIN_BITS + 1);

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = LEN_BITS;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_REGION_LENGTH   = 3'd0,
    REG_FADE_IN_LENGTH  = 3'd1,
    REG_FADE_OUT_LENGTH = 3'd2,
    REG_FADE_IN_SHAPE   = 3'd3,
    REG_FADE_OUT_SHAPE  = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    SHAPE_LINEAR = 2'd0,
    SHAPE_SQUARE = 2'd1,
    SHAPE_LOG    = 2'd2,
    SHAPE_COSINE = 2'd3
  } curve_shape_e;

  typedef logic [GAIN_BITS-1:0] curve_rom_t [CURVE_TABLE_DEPTH+1];

  localparam longint unsigned Q30_ONE       = 64'd1073741824;
  localparam longint unsigned HALF_PI_Q30   = 64'd1686629713;
  localparam longint unsigned LN2_Q30       = 64'd744261118;
  localparam longint unsigned LN10_Q30      = 64'd2472381918;
  localparam longint unsigned LN10_HALF_Q30 = LN10_Q30 / 2;

  // Restoring long division, used only while the tables are built.
  function automatic longint unsigned long_div(longint unsigned numer,
                                               longint unsigned denom);
    longint unsigned quot;
    longint unsigned rem;
    quot = 0;
    rem  = 0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], numer[b]};
      if (rem >= denom) begin
        rem     = rem - denom;
        quot[b] = 1'b1;
      end
    end
    return quot;
  endfunction

  // Raised cosine point, half of 1 - cos(pi p), computed as sin^2 of a quarter turn.
  function automatic logic [GAIN_BITS-1:0] cos_point(longint unsigned k);
    longint unsigned theta;
    longint unsigned th2;
    longint unsigned term;
    longint unsigned s;
    longint unsigned g;
    longint unsigned n;
    longint          sum;
    theta = (HALF_PI_Q30 * k) / CURVE_TABLE_DEPTH;
    th2   = (theta * theta) >> 30;
    term  = theta;
    sum   = longint'(theta);
    for (n = 1; n <= 9; n++) begin
      term = long_div((term * th2) >> 30, (2 * n) * (2 * n + 1));
      if (n[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    s = unsigned'(sum);
    if (s > Q30_ONE) begin
      s = Q30_ONE;
    end
    g = (s * s + (64'd1 << 43)) >> 44;
    if (g > 64'(GAIN_ONE)) begin
      g = 64'(GAIN_ONE);
    end
    return GAIN_BITS'(g);
  endfunction

  // Point of log10(1 + 9p) through an atanh series on the reduced mantissa.
  function automatic logic [GAIN_BITS-1:0] log_point(longint unsigned k);
    longint unsigned y;
    longint unsigned m;
    longint unsigned z;
    longint unsigned z2;
    longint unsigned pw;
    longint unsigned sum;
    longint unsigned ln;
    longint unsigned g;
    longint unsigned n;
    y = Q30_ONE + (64'd9 * Q30_ONE * k) / CURVE_TABLE_DEPTH;
    m = 0;
    while (y >= 2 * Q30_ONE) begin
      y = y >> 1;
      m = m + 1;
    end
    z   = long_div((y - Q30_ONE) << 30, y + Q30_ONE);
    z2  = (z * z) >> 30;
    sum = z;
    pw  = z;
    for (n = 1; n <= 14; n++) begin
      pw  = (pw * z2) >> 30;
      sum = sum + long_div(pw, 2 * n + 1);
    end
    ln = 2 * sum + m * LN2_Q30;
    g  = long_div(ln * 64'(GAIN_ONE) + LN10_HALF_Q30, LN10_Q30);
    if (g > 64'(GAIN_ONE)) begin
      g = 64'(GAIN_ONE);
    end
    return GAIN_BITS'(g);
  endfunction

  function automatic curve_rom_t build_cos_rom();
    curve_rom_t rom;
    for (int k = 0; k <= CURVE_TABLE_DEPTH; k++) begin
      rom[k] = cos_point(64'(k));
    end
    rom[0]                 = '0;
    rom[CURVE_TABLE_DEPTH] = GAIN_BITS'(GAIN_ONE);
    return rom;
  endfunction

  function automatic curve_rom_t build_log_rom();
    curve_rom_t rom;
    for (int k = 0; k <= CURVE_TABLE_DEPTH; k++) begin
      rom[k] = log_point(64'(k));
    end
    rom[0]                 = '0;
    rom[CURVE_TABLE_DEPTH] = GAIN_BITS'(GAIN_ONE);
    return rom;
  endfunction

endpackage

// ----- sv/fdg_rom.sv -----
// Log and raised cosine curve tables with two registered read ports.
module fdg_rom (
  input  logic                                clk_i,
  input  logic                                sel_cos_i,
  input  logic [fdg_pkg::CURVE_IDX_BITS-1:0]  addr0_i,
  input  logic [fdg_pkg::CURVE_IDX_BITS-1:0]  addr1_i,
  output logic [fdg_pkg::GAIN_BITS-1:0]       data0_o,
  output logic [fdg_pkg::GAIN_BITS-1:0]       data1_o
);
  import fdg_pkg::*;

  localparam curve_rom_t LOG_ROM = build_log_rom();
  localparam curve_rom_t COS_ROM = build_cos_rom();

  logic [GAIN_BITS-1:0] data0_q;
  logic [GAIN_BITS-1:0] data1_q;

  always_ff @(posedge clk_i) begin
    data0_q <= sel_cos_i ? COS_ROM[addr0_i] : LOG_ROM[addr0_i];
    data1_q <= sel_cos_i ? COS_ROM[addr1_i] : LOG_ROM[addr1_i];
  end

  assign data0_o = data0_q;
  assign data1_o = data1_q;

endmodule

// ----- sv/fdg_div.sv -----
// Bit-serial restoring divider producing a Q0.16 fraction of numerator over denominator.
module fdg_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [fdg_pkg::LEN_BITS-1:0]   numer_i,
  input  logic [fdg_pkg::LEN_BITS-1:0]   denom_i,
  output logic [fdg_pkg::FRAC_BITS-1:0]  quot_o,
  output logic                           done_o
);
  import fdg_pkg::*;

  logic [LEN_BITS-1:0]      rem_q;
  logic [LEN_BITS-1:0]      denom_q;
  logic [FRAC_BITS-1:0]     quot_q;
  logic [STEP_CNT_BITS-1:0] cnt_q;
  logic                     busy_q;
  logic                     done_q;
  logic [LEN_BITS:0]        rem_shl;
  logic [LEN_BITS:0]        trial;
  logic                     fits;

  // The numerator is always below the denominator, so the doubled remainder fits.
  assign rem_shl = {rem_q, 1'b0};
  assign trial   = rem_shl - {1'b0, denom_q};
  assign fits    = rem_shl >= {1'b0, denom_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == STEP_CNT_BITS'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= STEP_CNT_BITS'(FRAC_BITS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - STEP_CNT_BITS'(1);
        if (cnt_q == STEP_CNT_BITS'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q   <= numer_i;
      denom_q <= denom_i;
      quot_q  <= '0;
    end else if (busy_q) begin
      rem_q  <= fits ? trial[LEN_BITS-1:0] : rem_shl[LEN_BITS-1:0];
      quot_q <= {quot_q[FRAC_BITS-2:0], fits};
    end
  end

  assign quot_o = quot_q;
  assign done_o = done_q;

endmodule

// ----- sv/fdg_mul.sv -----
// Bit-serial shift-add multiplier of a signed multiplicand by an unsigned gain, scaled by 2^-16.
module fdg_mul (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic signed [fdg_pkg::MCAND_BITS-1:0] mcand_i,
  input  logic        [fdg_pkg::GAIN_BITS-1:0]  mplier_i,
  output logic signed [fdg_pkg::PROD_BITS-1:0]  prod_o,
  output logic                                  done_o
);
  import fdg_pkg::*;

  logic signed [MCAND_BITS-1:0] mcand_q;
  logic signed [MCAND_BITS:0]   hi_q;
  logic        [GAIN_BITS-1:0]  lo_q;
  logic [STEP_CNT_BITS-1:0]     cnt_q;
  logic                         busy_q;
  logic                         done_q;
  logic signed [MCAND_BITS:0]   addend;
  logic signed [MCAND_BITS:0]   sum;

  // The multiplier bits leave lo_q from the bottom while product bits enter from the top.
  assign addend = lo_q[0] ? {mcand_q[MCAND_BITS-1], mcand_q} : '0;
  assign sum    = hi_q + addend;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == STEP_CNT_BITS'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= STEP_CNT_BITS'(GAIN_BITS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - STEP_CNT_BITS'(1);
        if (cnt_q == STEP_CNT_BITS'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q <= mcand_i;
      hi_q    <= '0;
      lo_q    <= mplier_i;
    end else if (busy_q) begin
      hi_q <= {sum[MCAND_BITS], sum[MCAND_BITS:1]};
      lo_q <= {sum[0], lo_q[GAIN_BITS-1:1]};
    end
  end

  // Dropping the low FRAC_BITS of the two's complement product rounds toward minus infinity.
  assign prod_o = {hi_q, lo_q[GAIN_BITS-1:FRAC_BITS]};
  assign done_o = done_q;

endmodule

// ----- sv/fade_envelope_gain.sv -----
// Top level of the fade envelope gain block: configuration, position counter and sequencer.
// A sample outside both fades takes the shortest path through the sequencer, and one inside
// both fades the longest: each active fade costs a bit-serial division for the fade
// position (none at full scale), a bit-serial multiply for the square or table curves,
// and a bit-serial multiply to apply the gain, plus sequencing states; the single shared
// divider and multiplier serialize this work. A finished sample waits in the output register
// while the next request is taken. Log and cosine curves come from 1025-point tables with
// linear interpolation; reset needs no table initialization.
module fade_envelope_gain (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [fdg_pkg::CFG_IDX_BITS-1:0]       cfg_idx_i,
  input  logic [fdg_pkg::CFG_DATA_BITS-1:0]      cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [fdg_pkg::SAMPLE_BITS-1:0] sample_in_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [fdg_pkg::SAMPLE_BITS-1:0] sample_out_o,
  output logic                                   region_end_o
);
  import fdg_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE      = 10'b0000000001,
    ST_SETUP     = 10'b0000000010,
    ST_PHASE     = 10'b0000000100,
    ST_DIV       = 10'b0000001000,
    ST_CURVE     = 10'b0000010000,
    ST_ROM       = 10'b0000100000,
    ST_MUL_CURVE = 10'b0001000000,
    ST_GAIN      = 10'b0010000000,
    ST_MUL_GAIN  = 10'b0100000000,
    ST_DONE      = 10'b1000000000
  } state_e;

  localparam logic signed [PROD_BITS-1:0] SAT_HI =
    {{(PROD_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [PROD_BITS-1:0] SAT_LO =
    {{(PROD_BITS-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

  state_e state_q, state_d;

  logic [LEN_BITS-1:0] region_len_q;
  logic [LEN_BITS-1:0] fade_in_len_q;
  logic [LEN_BITS-1:0] fade_out_len_q;
  curve_shape_e        fade_in_shape_q;
  curve_shape_e        fade_out_shape_q;

  logic [POS_BITS-1:0] pos_q;
  logic [POS_BITS-1:0] pos_cur_q;
  logic [LEN_BITS-1:0] rem_len_q;
  logic                phase_out_q;
  logic                fin_act_q;
  logic                fout_act_q;
  logic                full_out_q;
  logic                end_q;

  logic signed [SAMPLE_BITS-1:0] s_q;
  logic [GAIN_BITS-1:0]          p_q;
  logic [GAIN_BITS-1:0]          g_q;
  logic [GAIN_BITS-1:0]          tk_q;

  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] sample_out_q;
  logic                          region_end_q;

  logic [LEN_BITS-1:0] len_eff;
  logic [LEN_BITS-1:0] nin;
  logic [LEN_BITS-1:0] nout;
  logic [LEN_BITS-1:0] pos_ext;
  logic [LEN_BITS-1:0] pos_inc;
  logic [LEN_BITS-1:0] rem_len;
  logic [POS_BITS-1:0] pos_wrap;
  curve_shape_e        cur_shape;
  logic                fade_act;
  logic                full_scale;
  logic                out_load;

  logic                      div_start;
  logic [LEN_BITS-1:0]       div_numer;
  logic [LEN_BITS-1:0]       div_denom;
  logic [FRAC_BITS-1:0]      div_quot;
  logic                      div_done;

  logic                          mul_start;
  logic signed [MCAND_BITS-1:0]  mul_mcand;
  logic [GAIN_BITS-1:0]          mul_mplier;
  logic signed [PROD_BITS-1:0]   mul_prod;
  logic                          mul_done;
  logic [SAMPLE_BITS-1:0]        sat_val;

  logic [CURVE_IDX_BITS-1:0] rom_addr0;
  logic [CURVE_IDX_BITS-1:0] rom_addr1;
  logic [GAIN_BITS-1:0]      rom_data0;
  logic [GAIN_BITS-1:0]      rom_data1;
  logic [GAIN_BITS-1:0]      rom_diff;
  logic [FRAC_BITS-1:0]      rom_frac;

  // Effective lengths: zero region means one sample, and fades never exceed the region.
  always_comb begin
    if (region_len_q == '0) begin
      len_eff = LEN_BITS'(1);
    end else if (region_len_q > LEN_BITS'(MAX_REGION_SAMPLES)) begin
      len_eff = LEN_BITS'(MAX_REGION_SAMPLES);
    end else begin
      len_eff = region_len_q;
    end
    nin  = (fade_in_len_q < len_eff) ? fade_in_len_q : len_eff;
    nout = (fade_out_len_q < len_eff) ? fade_out_len_q : len_eff;
  end

  assign pos_wrap = (LEN_BITS'(pos_q) >= len_eff) ? '0 : pos_q;
  assign pos_ext  = LEN_BITS'(pos_cur_q);
  assign pos_inc  = pos_ext + LEN_BITS'(1);
  // Distance to the region end; the fade-out is active once it drops to the fade-out length.
  assign rem_len  = len_eff - pos_ext;

  assign cur_shape  = phase_out_q ? fade_out_shape_q : fade_in_shape_q;
  assign fade_act   = phase_out_q ? fout_act_q : fin_act_q;
  assign full_scale = phase_out_q && full_out_q;
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  assign div_start = (state_q == ST_PHASE) && fade_act && !full_scale;
  assign div_numer = phase_out_q ? rem_len_q : pos_ext;
  assign div_denom = phase_out_q ? nout : nin;

  assign rom_addr0 = p_q[GAIN_BITS-1:FRAC_SHIFT];
  assign rom_addr1 = (rom_addr0 == CURVE_IDX_BITS'(CURVE_TABLE_DEPTH)) ? rom_addr0 :
                     rom_addr0 + CURVE_IDX_BITS'(1);
  assign rom_frac  = {p_q[FRAC_SHIFT-1:0], {CURVE_ADDR_BITS{1'b0}}};
  assign rom_diff  = (rom_data1 > rom_data0) ? rom_data1 - rom_data0 : '0;

  always_comb begin
    mul_start  = 1'b0;
    mul_mcand  = MCAND_BITS'(s_q);
    mul_mplier = g_q;
    case (state_q)
      ST_CURVE: begin
        mul_start  = (cur_shape == SHAPE_SQUARE);
        mul_mcand  = MCAND_BITS'(p_q);
        mul_mplier = p_q;
      end
      ST_ROM: begin
        mul_start  = 1'b1;
        mul_mcand  = MCAND_BITS'(rom_diff);
        mul_mplier = GAIN_BITS'(rom_frac);
      end
      ST_GAIN: begin
        mul_start = 1'b1;
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (mul_prod > SAT_HI) begin
      sat_val = SAT_HI[SAMPLE_BITS-1:0];
    end else if (mul_prod < SAT_LO) begin
      sat_val = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      sat_val = mul_prod[SAMPLE_BITS-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SETUP;
      end
      ST_SETUP: begin
        state_d = ST_PHASE;
      end
      ST_PHASE: begin
        if (!fade_act) begin
          state_d = phase_out_q ? ST_DONE : ST_PHASE;
        end else if (full_scale) begin
          state_d = ST_CURVE;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) state_d = ST_CURVE;
      end
      ST_CURVE: begin
        case (cur_shape)
          SHAPE_LINEAR: state_d = ST_GAIN;
          SHAPE_SQUARE: state_d = ST_MUL_CURVE;
          default:      state_d = ST_ROM;
        endcase
      end
      ST_ROM: begin
        state_d = ST_MUL_CURVE;
      end
      ST_MUL_CURVE: begin
        if (mul_done) state_d = ST_GAIN;
      end
      ST_GAIN: begin
        state_d = ST_MUL_GAIN;
      end
      ST_MUL_GAIN: begin
        if (mul_done) state_d = phase_out_q ? ST_DONE : ST_PHASE;
      end
      ST_DONE: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_IDLE;
      region_len_q     <= LEN_BITS'(1);
      fade_in_len_q    <= '0;
      fade_out_len_q   <= '0;
      fade_in_shape_q  <= SHAPE_LINEAR;
      fade_out_shape_q <= SHAPE_LINEAR;
      pos_q            <= '0;
      phase_out_q      <= 1'b0;
      out_valid_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_REGION_LENGTH:   region_len_q     <= cfg_data_i;
          REG_FADE_IN_LENGTH:  fade_in_len_q    <= cfg_data_i;
          REG_FADE_OUT_LENGTH: fade_out_len_q   <= cfg_data_i;
          REG_FADE_IN_SHAPE:   fade_in_shape_q  <= curve_shape_e'(cfg_data_i[1:0]);
          REG_FADE_OUT_SHAPE:  fade_out_shape_q <= curve_shape_e'(cfg_data_i[1:0]);
          default: ;
        endcase
      end
      if (state_q == ST_SETUP) begin
        pos_q       <= (pos_inc >= len_eff) ? '0 : pos_inc[POS_BITS-1:0];
        phase_out_q <= 1'b0;
      end else if ((state_q == ST_PHASE) && !fade_act) begin
        phase_out_q <= 1'b1;
      end else if ((state_q == ST_MUL_GAIN) && mul_done) begin
        phase_out_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          s_q       <= sample_in_i;
          pos_cur_q <= pos_wrap;
        end
      end
      ST_SETUP: begin
        rem_len_q  <= rem_len;
        fin_act_q  <= (nin != '0) && (pos_ext < nin);
        fout_act_q <= (nout != '0) && (rem_len <= nout);
        full_out_q <= (rem_len == nout);
        end_q      <= (pos_inc == len_eff);
      end
      ST_PHASE: begin
        if (full_scale) p_q <= GAIN_BITS'(GAIN_ONE);
      end
      ST_DIV: begin
        if (div_done) p_q <= {1'b0, div_quot};
      end
      ST_CURVE: begin
        if (cur_shape == SHAPE_LINEAR) g_q <= p_q;
      end
      ST_ROM: begin
        tk_q <= rom_data0;
      end
      ST_MUL_CURVE: begin
        if (mul_done) begin
          if (cur_shape == SHAPE_SQUARE) begin
            g_q <= mul_prod[GAIN_BITS-1:0];
          end else begin
            g_q <= tk_q + mul_prod[GAIN_BITS-1:0];
          end
        end
      end
      ST_MUL_GAIN: begin
        if (mul_done) s_q <= sat_val;
      end
      ST_DONE: begin
        if (out_load) begin
          sample_out_q <= s_q;
          region_end_q <= end_q;
        end
      end
      default: ;
    endcase
  end

  fdg_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .numer_i (div_numer),
    .denom_i (div_denom),
    .quot_o  (div_quot),
    .done_o  (div_done)
  );

  fdg_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  (mul_mcand),
    .mplier_i (mul_mplier),
    .prod_o   (mul_prod),
    .done_o   (mul_done)
  );

  fdg_rom u_rom (
    .clk_i     (clk_i),
    .sel_cos_i (cur_shape == SHAPE_COSINE),
    .addr0_i   (rom_addr0),
    .addr1_i   (rom_addr1),
    .data0_o   (rom_data0),
    .data1_o   (rom_data1)
  );

  assign in_ready_o   = (state_q == ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_out_q;
  assign region_end_o = region_end_q;

endmodule
